### sv/icl_pkg.sv
// icl_pkg: shared types and constants for the integer and character literal parser
// depends on nothing; used by int_char_literal_parser
package icl_pkg;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_HSKIP  = 4'd1,
    PH_HDIG   = 4'd2,
    PH_DDIG   = 4'd3,
    PH_ODIG   = 4'd4,
    PH_SUFFIX = 4'd5,
    PH_SUFL   = 4'd6,
    PH_CU8    = 4'd7,
    PH_CQUOTE = 4'd8,
    PH_CBODY  = 4'd9,
    PH_CESC   = 4'd10,
    PH_COCT   = 4'd11,
    PH_CHEX   = 4'd12,
    PH_CUTF   = 4'd13,
    PH_DONE   = 4'd14
  } phase_t;

  localparam logic [1:0] MODE_HEX  = 2'd0;
  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_OCT  = 2'd2;
  localparam logic [1:0] MODE_CHAR = 2'd3;

  localparam logic [1:0] KIND_LOCAL = 2'd0;
  localparam logic [1:0] KIND_UTF16 = 2'd1;
  localparam logic [1:0] KIND_UTF32 = 2'd2;
  localparam logic [1:0] KIND_UTF8  = 2'd3;

  // suffix flag bit positions
  localparam int SUF_U  = 0;
  localparam int SUF_L  = 1;
  localparam int SUF_LL = 2;

  localparam logic [63:0] LIMIT_HEX = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT_DEC = 64'h1999_9999_9999_9999;
  localparam logic [63:0] LIMIT_OCT = 64'h1FFF_FFFF_FFFF_FFFF;

  localparam logic [63:0] UTF_MASK  = 64'h0000_0000_FFFF_FFFF;

  localparam logic [6:0] SIZE_L  = 7'd32;
  localparam logic [6:0] SIZE_LL = 7'd64;

  typedef struct packed {
    logic        overflow;
    logic        is_signed;
    logic [6:0]  size_bits;
    logic [63:0] value;
  } res_t;

endpackage

### sv/int_char_literal_parser.sv
// int_char_literal_parser: one source byte per beat, value of a C integer or
// character constant on the beat marked last; depends on icl_pkg
// a result is registered in the output register, or the skid entry if that is held
// throughput: one byte per cycle while the skid entry is empty; a two-entry output
// stage (register plus skid) lets bytes keep flowing while a result waits
// reset (rst, synchronous): parse state back to start of literal, output empty
module int_char_literal_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic [1:0]  s_tuser,   // [1:0] mode
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [63:0] value, [70:64] size_bits, [71] is_signed,
                                 // [72] overflow, [79:73] zero
);

  icl_pkg::phase_t phase, phase_next;
  logic [63:0] acc, acc_next;
  logic        ovf, ovf_next;
  logic [2:0]  suf, suf_next;
  logic [1:0]  kind, kind_next;
  logic [2:0]  urem, urem_next;
  logic [1:0]  escd, escd_next;

  icl_pkg::res_t res, out_res, skid_res;
  logic          out_valid, skid_valid;

  logic [7:0] ch;
  logic [1:0] mode;
  logic       in_fire, push, pop;

  assign ch      = s_tdata;
  assign mode    = s_tuser;
  assign in_fire = s_tvalid && s_tready;
  assign push    = in_fire && s_tlast;
  assign pop     = out_valid && m_tready;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] r;
    if (c >= "0" && c <= "9") begin
      r = c - 8'h30;
    end else if (c >= "a" && c <= "z") begin
      r = c - 8'h57;
    end else if (c >= "A" && c <= "Z") begin
      r = c - 8'h37;
    end else begin
      r = 8'd36;
    end
    return r[5:0];
  endfunction

  function automatic icl_pkg::phase_t suffix_phase(input logic [7:0] c);
    if (c == "u" || c == "U") begin
      return icl_pkg::PH_SUFFIX;
    end else if (c == "l" || c == "L") begin
      return icl_pkg::PH_SUFL;
    end
    return icl_pkg::PH_DONE;
  endfunction

  function automatic logic is_u(input logic [7:0] c);
    return (c == "u" || c == "U");
  endfunction

  // next parse state for one byte
  always_comb begin : step
    logic [5:0]  d;
    logic [2:0]  more;
    logic [5:0]  lead_mask;
    phase_next = phase;
    acc_next   = acc;
    ovf_next   = ovf;
    suf_next   = suf;
    kind_next  = kind;
    urem_next  = urem;
    escd_next  = escd;
    d = digit_of(ch);
    if (ch >= 8'hFC) begin
      more = 3'd5;
    end else if (ch >= 8'hF8) begin
      more = 3'd4;
    end else if (ch >= 8'hF0) begin
      more = 3'd3;
    end else if (ch >= 8'hE0) begin
      more = 3'd2;
    end else begin
      more = 3'd1;
    end
    lead_mask = 6'h3F >> more;
    unique case (phase)
      icl_pkg::PH_START: begin
        unique case (mode)
          icl_pkg::MODE_HEX: begin
            phase_next = (ch == 8'd0) ? icl_pkg::PH_DONE : icl_pkg::PH_HSKIP;
          end
          icl_pkg::MODE_DEC: begin
            if (d < 6'd10) begin
              if (acc > icl_pkg::LIMIT_DEC) ovf_next = 1'b1;
              acc_next = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {58'd0, d};
            end else begin
              suf_next[icl_pkg::SUF_U] = suf[icl_pkg::SUF_U] | is_u(ch);
              phase_next = suffix_phase(ch);
            end
          end
          icl_pkg::MODE_OCT: begin
            if (d < 6'd8) begin
              if (acc > icl_pkg::LIMIT_OCT) ovf_next = 1'b1;
              acc_next = {acc[60:0], 3'b000} + {58'd0, d};
            end else begin
              suf_next[icl_pkg::SUF_U] = suf[icl_pkg::SUF_U] | is_u(ch);
              phase_next = suffix_phase(ch);
            end
          end
          default: begin
            if (ch == "u") begin
              kind_next  = icl_pkg::KIND_UTF16;
              phase_next = icl_pkg::PH_CU8;
            end else if (ch == "U" || ch == "L") begin
              kind_next  = icl_pkg::KIND_UTF32;
              phase_next = icl_pkg::PH_CQUOTE;
            end else begin
              phase_next = (ch == "'") ? icl_pkg::PH_CBODY : icl_pkg::PH_DONE;
            end
          end
        endcase
      end
      icl_pkg::PH_HSKIP: begin
        phase_next = (ch == 8'd0) ? icl_pkg::PH_DONE : icl_pkg::PH_HDIG;
      end
      icl_pkg::PH_HDIG: begin
        if (d < 6'd16) begin
          if (acc > icl_pkg::LIMIT_HEX) ovf_next = 1'b1;
          acc_next = {acc[59:0], d[3:0]};
        end else begin
          suf_next[icl_pkg::SUF_U] = suf[icl_pkg::SUF_U] | is_u(ch);
          phase_next = suffix_phase(ch);
        end
      end
      icl_pkg::PH_DDIG: begin
        if (d < 6'd10) begin
          if (acc > icl_pkg::LIMIT_DEC) ovf_next = 1'b1;
          acc_next = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {58'd0, d};
        end else begin
          suf_next[icl_pkg::SUF_U] = suf[icl_pkg::SUF_U] | is_u(ch);
          phase_next = suffix_phase(ch);
        end
      end
      icl_pkg::PH_ODIG: begin
        if (d < 6'd8) begin
          if (acc > icl_pkg::LIMIT_OCT) ovf_next = 1'b1;
          acc_next = {acc[60:0], 3'b000} + {58'd0, d};
        end else begin
          suf_next[icl_pkg::SUF_U] = suf[icl_pkg::SUF_U] | is_u(ch);
          phase_next = suffix_phase(ch);
        end
      end
      icl_pkg::PH_SUFFIX: begin
        suf_next[icl_pkg::SUF_U] = suf[icl_pkg::SUF_U] | is_u(ch);
        phase_next = suffix_phase(ch);
      end
      icl_pkg::PH_SUFL: begin
        if (ch == "l" || ch == "L") begin
          suf_next[icl_pkg::SUF_LL] = 1'b1;
          phase_next = icl_pkg::PH_SUFFIX;
        end else begin
          suf_next[icl_pkg::SUF_L] = 1'b1;
          suf_next[icl_pkg::SUF_U] = suf[icl_pkg::SUF_U] | is_u(ch);
          phase_next = suffix_phase(ch);
        end
      end
      icl_pkg::PH_CU8: begin
        if (ch == "8") begin
          kind_next  = icl_pkg::KIND_UTF8;
          phase_next = icl_pkg::PH_CQUOTE;
        end else begin
          phase_next = (ch == "'") ? icl_pkg::PH_CBODY : icl_pkg::PH_DONE;
        end
      end
      icl_pkg::PH_CQUOTE: begin
        phase_next = (ch == "'") ? icl_pkg::PH_CBODY : icl_pkg::PH_DONE;
      end
      icl_pkg::PH_CBODY: begin
        if (ch == "\\") begin
          phase_next = icl_pkg::PH_CESC;
        end else if (ch == 8'd0) begin
          phase_next = icl_pkg::PH_DONE;
        end else if (kind != icl_pkg::KIND_LOCAL && ch >= 8'hC0 && ch < 8'hFE) begin
          acc_next   = {58'd0, ch[5:0] & lead_mask};
          urem_next  = more;
          phase_next = icl_pkg::PH_CUTF;
        end else begin
          acc_next   = {56'd0, ch};
          phase_next = icl_pkg::PH_DONE;
        end
      end
      icl_pkg::PH_CESC: begin
        phase_next = icl_pkg::PH_DONE;
        case (ch)
          "'", "\"", "?", "\\": acc_next = {56'd0, ch};
          "a": acc_next = 64'd7;
          "b": acc_next = 64'd8;
          "f": acc_next = 64'd12;
          "n": acc_next = 64'd10;
          "r": acc_next = 64'd13;
          "t": acc_next = 64'd9;
          "v": acc_next = 64'd11;
          "x": begin
            acc_next   = 64'd0;
            phase_next = icl_pkg::PH_CHEX;
          end
          default: begin
            if (ch >= "0" && ch <= "7") begin
              acc_next   = {61'd0, ch[2:0]};
              escd_next  = 2'd0;
              phase_next = icl_pkg::PH_COCT;
            end else begin
              acc_next = 64'd0;
            end
          end
        endcase
      end
      icl_pkg::PH_COCT: begin
        if (ch >= "0" && ch <= "7") begin
          acc_next  = {acc[60:0], ch[2:0]};
          escd_next = escd + 2'd1;
          if (escd_next >= 2'd2) phase_next = icl_pkg::PH_DONE;
        end else begin
          phase_next = icl_pkg::PH_DONE;
        end
      end
      icl_pkg::PH_CHEX: begin
        if (d < 6'd16) begin
          if (acc > icl_pkg::LIMIT_HEX) ovf_next = 1'b1;
          acc_next = {acc[59:0], d[3:0]};
        end else begin
          phase_next = icl_pkg::PH_DONE;
        end
      end
      icl_pkg::PH_CUTF: begin
        if (ch[7:6] == 2'b10) begin
          acc_next  = {acc[57:0], ch[5:0]} & icl_pkg::UTF_MASK;
          urem_next = urem - 3'd1;
          if (urem_next == 3'd0) phase_next = icl_pkg::PH_DONE;
        end else begin
          acc_next   = (acc << (5'(urem) * 5'd6)) & icl_pkg::UTF_MASK;
          urem_next  = 3'd0;
          phase_next = icl_pkg::PH_DONE;
        end
      end
      icl_pkg::PH_DONE: phase_next = icl_pkg::PH_DONE;
      default: phase_next = icl_pkg::PH_DONE;
    endcase
  end

  // result for a byte marked last
  always_comb begin : finish
    logic [63:0] v;
    logic [2:0]  fs;
    logic [6:0]  auto_sz;
    logic [6:0]  sz;
    if (phase_next == icl_pkg::PH_CUTF) begin
      v = (acc_next << (5'(urem_next) * 5'd6)) & icl_pkg::UTF_MASK;
    end else begin
      v = acc_next;
    end
    fs = suf_next;
    if (phase_next == icl_pkg::PH_SUFL) fs[icl_pkg::SUF_L] = 1'b1;
    auto_sz = 7'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[8*i +: 8] != 8'd0) auto_sz = 7'(8 * (i + 1));
    end
    if (fs[icl_pkg::SUF_LL]) begin
      sz = icl_pkg::SIZE_LL;
    end else if (fs[icl_pkg::SUF_L]) begin
      sz = icl_pkg::SIZE_L;
    end else begin
      sz = 7'd0;
    end
    if (sz < auto_sz) sz = auto_sz;
    res.value     = v;
    res.size_bits = sz;
    res.is_signed = ~fs[icl_pkg::SUF_U];
    res.overflow  = ovf_next | (~fs[icl_pkg::SUF_U] & v[63]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= icl_pkg::PH_START;
      acc   <= 64'd0;
      ovf   <= 1'b0;
      suf   <= 3'd0;
      kind  <= icl_pkg::KIND_LOCAL;
      urem  <= 3'd0;
      escd  <= 2'd0;
    end else if (in_fire) begin
      if (s_tlast) begin
        phase <= icl_pkg::PH_START;
        acc   <= 64'd0;
        ovf   <= 1'b0;
        suf   <= 3'd0;
        kind  <= icl_pkg::KIND_LOCAL;
        urem  <= 3'd0;
        escd  <= 2'd0;
      end else begin
        phase <= phase_next;
        acc   <= acc_next;
        ovf   <= ovf_next;
        suf   <= suf_next;
        kind  <= kind_next;
        urem  <= urem_next;
        escd  <= escd_next;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (push) begin
      skid_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_res <= skid_res;
    end else if (push && (!out_valid || pop)) begin
      out_res <= res;
    end else if (push) begin
      skid_res <= res;
    end
  end

  assign s_tready = ~skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.overflow, out_res.is_signed, out_res.size_bits,
                     out_res.value};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> phase == icl_pkg::PH_START)
    else $error("parse state not cleared after last beat");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.size_bits <= icl_pkg::SIZE_LL)
    else $error("size beyond 64 bits");

  a_signed_top_bit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.is_signed && out_res.value[63]) |-> out_res.overflow)
    else $error("signed value with top bit set not flagged");

endmodule
